// ----- src/aden_pkg.sv -----
package aden_pkg;

    localparam int LEVEL_WIDTH_DEFAULT = 24;
    localparam int COUNT_WIDTH_DEFAULT = 24;

    localparam int LEVEL_OUT_W = 24;
    localparam int START_W     = 24;
    localparam int COEFF_W     = 23;
    localparam int LEN_W       = 24;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam int COEFF_FRAC  = 22;

    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_LEVEL   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ATTACK_COEFF = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DECAY_COEFF  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ATTACK_LEN   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DECAY_LEN    = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ATTACK = 2'd1,
        PH_DECAY  = 2'd2
    } phase_t;

    typedef struct packed {
        logic        [START_W-1:0] init_level;
        logic signed [COEFF_W-1:0] attack_coeff;
        logic signed [COEFF_W-1:0] decay_coeff;
        logic        [LEN_W-1:0]   attack_len;
        logic        [LEN_W-1:0]   decay_len;
    } cfg_t;

endpackage

// ----- src/aden_in_if.sv -----
interface aden_in_if ();
    logic valid;
    logic ready;
    logic gate_in;
    logic trigger_in;
    logic reset_in;

    modport source (output valid, output gate_in, output trigger_in, output reset_in,
                    input ready);
    modport sink (input valid, input gate_in, input trigger_in, input reset_in,
                  output ready);
endinterface

// ----- src/aden_out_if.sv -----
interface aden_out_if import aden_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [LEVEL_OUT_W-1:0] level_out;

    modport source (output valid, output level_out, input ready);
    modport sink (input valid, input level_out, output ready);
endinterface

// ----- src/aden_cfg_regs.sv -----
module aden_cfg_regs import aden_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_INIT_LEVEL:   cfg_next.init_level   = cfg_data[START_W-1:0];
                CFG_ATTACK_COEFF: cfg_next.attack_coeff = $signed(cfg_data[COEFF_W-1:0]);
                CFG_DECAY_COEFF:  cfg_next.decay_coeff  = $signed(cfg_data[COEFF_W-1:0]);
                CFG_ATTACK_LEN:   cfg_next.attack_len   = cfg_data[LEN_W-1:0];
                CFG_DECAY_LEN:    cfg_next.decay_len    = cfg_data[LEN_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/aden_grow.sv -----
module aden_grow import aden_pkg::*;
#(
    parameter int LEVEL_WIDTH = LEVEL_WIDTH_DEFAULT
)
(
    input  logic        [LEVEL_WIDTH-1:0] level,
    input  logic signed [COEFF_W-1:0]     coeff,
    output logic        [LEVEL_WIDTH-1:0] level_grown
);

    localparam int PROD_W = LEVEL_WIDTH + 1 + COEFF_W;
    localparam int Q_W    = PROD_W + 1;
    localparam int D_W    = Q_W - COEFF_FRAC;
    localparam int N_W    = LEVEL_WIDTH + 4;

    // half an lsb of the signed Q26.22 product, for round half up
    localparam logic signed [Q_W-1:0] HALF =
        {{(Q_W - COEFF_FRAC){1'b0}}, 1'b1, {(COEFF_FRAC - 1){1'b0}}};

    logic signed [LEVEL_WIDTH:0] level_s;
    logic signed [PROD_W-1:0]    prod;
    logic signed [Q_W-1:0]       q;
    logic signed [D_W-1:0]       delta;
    logic signed [N_W-1:0]       sum;

    always_comb
    begin
        level_s = $signed({1'b0, level});
        prod    = PROD_W'(level_s) * PROD_W'(coeff);
        q       = $signed({prod[PROD_W-1], prod}) + HALF;
        // arithmetic shift right is floor division
        delta   = q[Q_W-1:COEFF_FRAC];
        sum     = $signed({4'b0000, level}) + $signed({{(N_W - D_W){delta[D_W-1]}}, delta});
        if (sum[N_W-1])
        begin
            level_grown = '0;
        end
        else if (sum[N_W-2:LEVEL_WIDTH] != '0)
        begin
            level_grown = '1;
        end
        else
        begin
            level_grown = sum[LEVEL_WIDTH-1:0];
        end
    end

endmodule

// ----- src/aden_core.sv -----
module aden_core import aden_pkg::*;
#(
    parameter int LEVEL_WIDTH = LEVEL_WIDTH_DEFAULT,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   gate,
    input  logic                   trigger,
    input  logic                   level_reset,
    input  cfg_t                   cfg,
    output logic [LEVEL_OUT_W-1:0] level_result
);

    localparam int LX_W = LEVEL_WIDTH + START_W;
    localparam int CX_W = COUNT_WIDTH + LEN_W;

    localparam logic [LX_W-1:0] LEVEL_MAX_X = {{START_W{1'b0}}, {LEVEL_WIDTH{1'b1}}};
    localparam logic [CX_W-1:0] COUNT_MAX_X = {{LEN_W{1'b0}}, {COUNT_WIDTH{1'b1}}};

    phase_t                   phase_reg;
    phase_t                   phase_next;
    logic [LEVEL_WIDTH-1:0]   level_reg;
    logic [LEVEL_WIDTH-1:0]   level_next;
    logic [COUNT_WIDTH-1:0]   count_reg;
    logic [COUNT_WIDTH-1:0]   count_next;
    logic                     prev_gate_reg;
    logic                     prev_trigger_reg;
    logic                     prev_reset_reg;

    logic                     start_edge;
    logic [LX_W-1:0]          start_x;
    logic [LEVEL_WIDTH-1:0]   start_lim;
    phase_t                   phase_mid;
    logic [COUNT_WIDTH-1:0]   count_mid;
    logic [LEVEL_WIDTH-1:0]   level_mid;
    logic [LEVEL_WIDTH-1:0]   level_src;
    logic [LEN_W-1:0]         len_sel;
    logic [CX_W-1:0]          len_x;
    logic [CX_W-1:0]          len_lim;
    logic                     phase_done;
    logic signed [COEFF_W-1:0] coeff_sel;
    logic [LEVEL_WIDTH-1:0]   level_grown;
    logic [LX_W-1:0]          level_x;

    aden_grow #(
        .LEVEL_WIDTH (LEVEL_WIDTH)
    ) u_grow (
        .level       (level_src),
        .coeff       (coeff_sel),
        .level_grown (level_grown)
    );

    always_comb
    begin
        start_edge = (trigger && !prev_trigger_reg) || (gate && !prev_gate_reg);

        start_x = {{LEVEL_WIDTH{1'b0}}, cfg.init_level};
        if (start_x > LEVEL_MAX_X)
        begin
            start_lim = '1;
        end
        else
        begin
            start_lim = start_x[LEVEL_WIDTH-1:0];
        end

        phase_mid = phase_reg;
        count_mid = count_reg;
        if (start_edge)
        begin
            if (cfg.attack_len != '0)
            begin
                phase_mid = PH_ATTACK;
            end
            count_mid = '0;
        end

        level_mid = (level_reset && !prev_reset_reg) ? start_lim : level_reg;

        // attack reloads the start level on its first sample
        if (phase_mid == PH_ATTACK && count_mid == '0)
        begin
            level_src = start_lim;
        end
        else
        begin
            level_src = level_mid;
        end

        if (phase_mid == PH_ATTACK)
        begin
            len_sel   = cfg.attack_len;
            coeff_sel = cfg.attack_coeff;
        end
        else
        begin
            len_sel   = cfg.decay_len;
            coeff_sel = cfg.decay_coeff;
        end

        len_x = {{COUNT_WIDTH{1'b0}}, len_sel};
        len_lim = (len_x > COUNT_MAX_X) ? COUNT_MAX_X : len_x;
        phase_done = {{LEN_W{1'b0}}, count_mid} >= len_lim;

        phase_next = phase_mid;
        count_next = count_mid;
        level_next = level_mid;
        case (phase_mid)
            PH_IDLE:
            begin
                level_next = level_mid;
            end
            PH_ATTACK, PH_DECAY:
            begin
                if (phase_done)
                begin
                    count_next = '0;
                    level_next = level_src;
                    phase_next = (phase_mid == PH_ATTACK) ? PH_DECAY : PH_IDLE;
                end
                else
                begin
                    count_next = count_mid + COUNT_WIDTH'(1);
                    level_next = level_grown;
                end
            end
            default:
            begin
                level_next = '0;
                phase_next = PH_IDLE;
            end
        endcase

        level_x      = {{START_W{1'b0}}, level_next};
        level_result = level_x[LEVEL_OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            level_reg        <= '0;
            count_reg        <= '0;
            prev_gate_reg    <= 1'b0;
            prev_trigger_reg <= 1'b0;
            prev_reset_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            level_reg        <= level_next;
            count_reg        <= count_next;
            prev_gate_reg    <= gate;
            prev_trigger_reg <= trigger;
            prev_reset_reg   <= level_reset;
        end
    end

endmodule

// ----- src/exponential_ad_envelope_top.sv -----
// channel    dir  payload                          handshake
// sample     in   gate_in, trigger_in, reset_in     valid / ready
// envelope   out  level_out (24 bit, Q8.16)         valid / ready
// cfg        in   cfg_index, cfg_data               cfg_wr_en, no wait
//
// one sample per clock sustained while envelope is ready; level_out comes from the sample
// transfer through the input register, then one multiply-add into the result register
// the single multiplier in the update path sets the clock, not the rate
// rst_n clears envelope state, handshake valids and config registers at once
// a stall on envelope holds the result register; the input register still
// takes one sample, then sample.ready drops until the result is taken
module exponential_ad_envelope_top import aden_pkg::*;
#(
    parameter int LEVEL_WIDTH = LEVEL_WIDTH_DEFAULT,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    aden_in_if.sink                sample,
    aden_out_if.source             envelope,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t                   cfg;
    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic                   gate_reg;
    logic                   trigger_reg;
    logic                   level_reset_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [LEVEL_OUT_W-1:0] level_out_reg;
    logic [LEVEL_OUT_W-1:0] level_result;
    logic                   step;
    logic                   in_xfer;

    aden_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    aden_core #(
        .LEVEL_WIDTH (LEVEL_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .gate         (gate_reg),
        .trigger      (trigger_reg),
        .level_reset  (level_reset_reg),
        .cfg          (cfg),
        .level_result (level_result)
    );

    always_comb
    begin
        step         = in_valid_reg && (!out_valid_reg || envelope.ready);
        sample.ready = !in_valid_reg || step;
        in_xfer      = sample.valid && sample.ready;

        if (in_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end

        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (envelope.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            gate_reg        <= sample.gate_in;
            trigger_reg     <= sample.trigger_in;
            level_reset_reg <= sample.reset_in;
        end
        if (step)
        begin
            level_out_reg <= level_result;
        end
    end

    assign envelope.valid     = out_valid_reg;
    assign envelope.level_out = level_out_reg;

endmodule

// ----- sim/aden_checker.sv -----
`timescale 1ns / 100ps

module aden_checker import aden_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    aden_in_if                     sample,
    aden_out_if                    envelope,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     levels_pending
);

    localparam longint LEVEL_MAX = (longint'(1) <<< LEVEL_OUT_W) - 1;

    cfg_t                   regs;
    phase_t                 env_phase;
    logic [LEVEL_OUT_W-1:0] env_level;
    logic [LEN_W-1:0]       env_count;
    logic                   prior_gate;
    logic                   prior_trigger;
    logic                   prior_reset;
    logic [LEVEL_OUT_W-1:0] level_q[$];
    int                     errors;

    assign fail_count = errors;

    function automatic logic [LEVEL_OUT_W-1:0] scale_level(logic [LEVEL_OUT_W-1:0] cur,
                                                           logic signed [COEFF_W-1:0] k);
        longint prod;
        longint nxt;
        prod = longint'(cur) * longint'(k) + (longint'(1) <<< (COEFF_FRAC - 1));
        nxt  = longint'(cur) + (prod >>> COEFF_FRAC);
        if (nxt < 0)
            nxt = 0;
        else if (nxt > LEVEL_MAX)
            nxt = LEVEL_MAX;
        return nxt[LEVEL_OUT_W-1:0];
    endfunction

    // one step of a timed phase, returns 1 once the phase has run its length
    function automatic bit advance_phase(logic [LEN_W-1:0] len,
                                         logic signed [COEFF_W-1:0] k);
        if (env_count >= len)
        begin
            env_count = '0;
            return 1'b1;
        end
        env_count = env_count + LEN_W'(1);
        env_level = scale_level(env_level, k);
        return 1'b0;
    endfunction

    function automatic logic [LEVEL_OUT_W-1:0] next_level(logic g, logic t, logic r);
        if ((t && !prior_trigger) || (g && !prior_gate))
        begin
            if (regs.attack_len != '0)
                env_phase = PH_ATTACK;
            env_count = '0;
        end
        if (r && !prior_reset)
            env_level = regs.init_level;
        case (env_phase)
            PH_ATTACK:
            begin
                if (env_count == '0)
                    env_level = regs.init_level;
                if (advance_phase(regs.attack_len, regs.attack_coeff))
                    env_phase = PH_DECAY;
            end
            PH_DECAY:
            begin
                if (advance_phase(regs.decay_len, regs.decay_coeff))
                    env_phase = PH_IDLE;
            end
            default:
            begin
            end
        endcase
        prior_gate    = g;
        prior_trigger = t;
        prior_reset   = r;
        return env_level;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs           = '0;
            env_phase      = PH_IDLE;
            env_level      = '0;
            env_count      = '0;
            prior_gate     = 1'b0;
            prior_trigger  = 1'b0;
            prior_reset    = 1'b0;
            level_q.delete();
            errors         = 0;
            levels_pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_INIT_LEVEL:   regs.init_level   = cfg_data[START_W-1:0];
                    CFG_ATTACK_COEFF: regs.attack_coeff = cfg_data[COEFF_W-1:0];
                    CFG_DECAY_COEFF:  regs.decay_coeff  = cfg_data[COEFF_W-1:0];
                    CFG_ATTACK_LEN:   regs.attack_len   = cfg_data[LEN_W-1:0];
                    CFG_DECAY_LEN:    regs.decay_len    = cfg_data[LEN_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (envelope.valid && envelope.ready)
            begin
                if (level_q.size() == 0)
                begin
                    $error("level_out: expected none, actual %h", envelope.level_out);
                    errors++;
                end
                else if (envelope.level_out !== level_q[0])
                begin
                    $error("level_out: expected %h, actual %h", level_q[0],
                           envelope.level_out);
                    errors++;
                    void'(level_q.pop_front());
                end
                else
                    void'(level_q.pop_front());
            end
            if (sample.valid && sample.ready)
                level_q.push_back(next_level(sample.gate_in, sample.trigger_in,
                                             sample.reset_in));
            levels_pending <= level_q.size();
        end
    end

endmodule

// ----- sim/exponential_ad_envelope_top_tb.sv -----
`timescale 1ns / 100ps

module exponential_ad_envelope_top_tb import aden_pkg::*;
();

    localparam int CLK_PERIOD = 12;
    localparam int TIMEOUT_NS = 4000000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 6;

    // {gate, trigger, reset}
    localparam logic [2:0] DIRECTED [22] = '{
        3'b000, 3'b001, 3'b000, 3'b010, 3'b000, 3'b000, 3'b000, 3'b000,
        3'b000, 3'b000, 3'b000, 3'b100, 3'b100, 3'b110, 3'b100, 3'b011,
        3'b111, 3'b101, 3'b000, 3'b001, 3'b000, 3'b000
    };

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     fail_count;
    int                     levels_pending;
    bit                     steady_flow;
    bit                     hold_request;
    logic                   gate_now;
    logic                   trigger_now;
    logic                   reset_now;

    aden_in_if  sample_if ();
    aden_out_if envelope_if ();

    exponential_ad_envelope_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_if),
        .envelope  (envelope_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    aden_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample         (sample_if),
        .envelope       (envelope_if),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .levels_pending (levels_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        envelope_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                envelope_if.ready <= 1'b0;
            end
            else
                envelope_if.ready <= steady_flow || ($urandom_range(99) >= 20);
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic load_config(input cfg_t c);
        write_reg(CFG_INIT_LEVEL, c.init_level);
        write_reg(CFG_ATTACK_COEFF, {1'($urandom_range(1)), c.attack_coeff});
        write_reg(CFG_DECAY_COEFF, {1'($urandom_range(1)), c.decay_coeff});
        write_reg(CFG_ATTACK_LEN, c.attack_len);
        write_reg(CFG_DECAY_LEN, c.decay_len);
        if ($urandom_range(1) == 1)
            write_reg(CFG_INDEX_W'(CFG_DECAY_LEN + 1 + $urandom_range(2)), CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sample(input logic g, input logic t, input logic r);
        if (!steady_flow)
        begin
            while ($urandom_range(99) < 20)
            begin
                sample_if.valid <= 1'b0;
                @(posedge clk);
            end
        end
        sample_if.valid      <= 1'b1;
        sample_if.gate_in    <= g;
        sample_if.trigger_in <= t;
        sample_if.reset_in   <= r;
        gate_now    = g;
        trigger_now = t;
        reset_now   = r;
        @(posedge clk);
        while (!sample_if.ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        sample_if.valid <= 1'b0;
        @(posedge clk);
        while (levels_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly slow edges on held gate/trigger lines so envelopes run their course
    task automatic run_envelopes(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 10)
                send_sample(1'($urandom), 1'($urandom), 1'($urandom));
            else
                send_sample(gate_now ^ ($urandom_range(99) < 8),
                            trigger_now ^ ($urandom_range(99) < 8),
                            reset_now ^ ($urandom_range(99) < 4));
        end
    endtask

    function automatic cfg_t random_cfg();
        cfg_t c;
        if ($urandom_range(3) == 0)
            c.init_level = START_W'($urandom);
        else
            c.init_level = START_W'($urandom_range(24'h020000, 24'h000100));
        if ($urandom_range(3) == 0)
        begin
            c.attack_coeff = COEFF_W'($urandom);
            c.decay_coeff  = COEFF_W'($urandom);
        end
        else
        begin
            c.attack_coeff = COEFF_W'($urandom_range(23'h100000));
            c.decay_coeff  = -COEFF_W'($urandom_range(23'h100000));
        end
        c.attack_len = ($urandom_range(7) == 0) ? '0 : LEN_W'($urandom_range(24, 1));
        c.decay_len  = LEN_W'($urandom_range(30));
        return c;
    endfunction

    initial
    begin
        cfg_t c;
        rst_n                = 1'b0;
        cfg_wr_en            <= 1'b0;
        cfg_index            <= '0;
        cfg_data             <= '0;
        sample_if.valid      <= 1'b0;
        sample_if.gate_in    <= 1'b0;
        sample_if.trigger_in <= 1'b0;
        sample_if.reset_in   <= 1'b0;
        gate_now             = 1'b0;
        trigger_now          = 1'b0;
        reset_now            = 1'b0;
        steady_flow          = 1'b0;
        hold_request         = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        c.init_level   = 24'h010000;
        c.attack_coeff = 23'h100000;
        c.decay_coeff  = -23'sh080000;
        c.attack_len   = 24'd3;
        c.decay_len    = 24'd2;
        load_config(c);
        foreach (DIRECTED[i])
            send_sample(DIRECTED[i][2], DIRECTED[i][1], DIRECTED[i][0]);
        wait_drained();

        // saturation upward during attack, full negative decay, one-sample decay
        c.init_level   = 24'hFFFFFF;
        c.attack_coeff = 23'h3FFFFF;
        c.decay_coeff  = 23'h400000;
        c.attack_len   = 24'd5;
        c.decay_len    = 24'd0;
        load_config(c);
        run_envelopes(60);
        wait_drained();

        // zero start level and no attack entry
        c.init_level   = 24'h000000;
        c.attack_coeff = 23'h0C0000;
        c.decay_coeff  = -23'sh020000;
        c.attack_len   = 24'd0;
        c.decay_len    = 24'd7;
        load_config(c);
        run_envelopes(60);
        wait_drained();

        c.init_level   = 24'h000200;
        c.attack_coeff = 23'h000400;
        c.decay_coeff  = -23'sh000400;
        c.attack_len   = 24'hFFFFFF;
        c.decay_len    = 24'hFFFFFF;
        load_config(c);
        run_envelopes(40);
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            load_config(random_cfg());
            steady_flow = (p == 2) || (p == 5);
            if (p == 5)
                hold_request = 1'b1;
            run_envelopes(100);
            steady_flow = 1'b0;
            wait_drained();
        end

        if (fail_count == 0 && levels_pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/aden_pkg.sv
src/aden_in_if.sv
src/aden_out_if.sv
src/aden_cfg_regs.sv
src/aden_grow.sv
src/aden_core.sv
src/exponential_ad_envelope_top.sv
sim/aden_checker.sv
sim/exponential_ad_envelope_top_tb.sv
